FILE: hw/rtl/logistic_quality_score_unit_assert.svh
// Assertion macros shared by the scorer RTL.
// LQS_ASSERT checks a property on every rising clock edge outside reset.
// LQS_ASSERT_NEXT checks that a condition is followed in the next cycle by another.
`ifndef LOGISTIC_QUALITY_SCORE_UNIT_ASSERT_SVH
`define LOGISTIC_QUALITY_SCORE_UNIT_ASSERT_SVH
`ifndef SYNTH
`define LQS_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("lqs assertion failed");
`define LQS_ASSERT_NEXT(name, ante, cons) \
  `LQS_ASSERT(name, (ante) |=> (cons))
`else
`define LQS_ASSERT(name, prop)
`define LQS_ASSERT_NEXT(name, ante, cons)
`endif
`endif

FILE: hw/rtl/lqs_pkg.sv
`default_nettype none

package lqs_pkg;

  localparam int NUM_REGS = 7;
  localparam int FRAC_W   = 16;

  typedef logic [2:0] reg_idx_t;
  typedef logic signed [23:0] coef_t;
  typedef logic [30:0] q230_t;

  localparam reg_idx_t REG_W_CHARGE_COS = 3'd0;
  localparam reg_idx_t REG_W_CHARGE_SNR = 3'd1;
  localparam reg_idx_t REG_W_ISO_COS    = 3'd2;
  localparam reg_idx_t REG_W_SNR        = 3'd3;
  localparam reg_idx_t REG_W_CHARGE_FIT = 3'd4;
  localparam reg_idx_t REG_W_PPM        = 3'd5;
  localparam reg_idx_t REG_INTERCEPT    = 3'd6;

  localparam coef_t RST_W_CHARGE_COS = -24'sd6167;
  localparam coef_t RST_W_CHARGE_SNR = -24'sd129789;
  localparam coef_t RST_W_ISO_COS    = -24'sd835728;
  localparam coef_t RST_W_SNR        = 24'sd17184;
  localparam coef_t RST_W_CHARGE_FIT = -24'sd81468;
  localparam coef_t RST_W_PPM        = 24'sd5341;
  localparam coef_t RST_INTERCEPT    = 24'sd886335;

  // log2(e) in Q.16
  localparam logic signed [17:0] LOG2E_Q16 = 18'sd94548;

  typedef struct packed {
    logic        empty;
    logic [15:0] cos_c;
    logic [15:0] cos_i;
    logic [15:0] score;
    q230_t       ppm_y;
    logic [2:0]  ppm_int;
  } front_side_t;

  typedef struct packed {
    logic       empty;
    logic [2:0] ppm_int;
  } log_side_t;

  typedef struct packed {
    logic              empty;
    logic              sat_lo;
    logic              sat_hi;
    logic signed [5:0] n;
  } exp_side_t;

  typedef struct packed {
    logic empty;
    logic sat_lo;
    logic sat_hi;
  } div_side_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] x);
    logic [63:0] res;
    logic [63:0] bit_v;
    logic [63:0] r;
    res   = '0;
    bit_v = 64'h4000_0000_0000_0000;
    r     = x;
    for (int k = 0; k < 32; k++) begin
      if (bit_v > r) bit_v = bit_v >> 2;
    end
    for (int k = 0; k < 32; k++) begin
      if (bit_v != '0) begin
        if (r >= res + bit_v) begin
          r   = r - (res + bit_v);
          res = (res >> 1) + bit_v;
        end else begin
          res = res >> 1;
        end
        bit_v = bit_v >> 2;
      end
    end
    return res;
  endfunction

  // 2^(2^-idx) in Q1.30, by repeated square roots of 2.0
  function automatic q230_t exp2_coef(input int idx);
    logic [63:0] c;
    c = 64'd1 << 31;
    for (int k = 1; k <= FRAC_W; k++) begin
      if (k <= idx) c = isqrt64(c << 30);
    end
    return c[30:0];
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/logistic_quality_score_unit.sv
// Logistic quality scorer: log2 features, weighted sum, q = 1/(1+exp(sum)) in Q0.16.
// Throughput: one feature set per clock; busy_o stays low and the pipeline never stalls.
// The pipeline is built from the two restoring dividers, the two 16-step log2 and exp2 units and the sum registers.
// Reset clears all valid bits and loads the weight and intercept registers with defaults.
`default_nettype none
`include "logistic_quality_score_unit_assert.svh"

module logistic_quality_score_unit (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic [15:0]             charge_cosine_i,
  input  logic [31:0]             charge_snr_i,
  input  logic [15:0]             isotope_cosine_i,
  input  logic [31:0]             overall_snr_i,
  input  logic [15:0]             charge_fit_score_i,
  input  logic signed [15:0]      mean_ppm_error_i,
  input  logic                    group_empty_i,
  input  logic                    cfg_we_i,
  input  lqs_pkg::reg_idx_t       cfg_idx_i,
  input  logic [23:0]             cfg_wdata_i,
  output logic                    done_o,
  output logic [15:0]             quality_o
);

  import lqs_pkg::*;

  localparam int LATENCY = 71;

  // ---------------------------------------------------------------------------
  // Configuration registers: weights and intercept, to be written by the user only while idle; unenforced here
  // ---------------------------------------------------------------------------
  coef_t coef_q [NUM_REGS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q[REG_W_CHARGE_COS] <= RST_W_CHARGE_COS;
      coef_q[REG_W_CHARGE_SNR] <= RST_W_CHARGE_SNR;
      coef_q[REG_W_ISO_COS]    <= RST_W_ISO_COS;
      coef_q[REG_W_SNR]        <= RST_W_SNR;
      coef_q[REG_W_CHARGE_FIT] <= RST_W_CHARGE_FIT;
      coef_q[REG_W_PPM]        <= RST_W_PPM;
      coef_q[REG_INTERCEPT]    <= RST_INTERCEPT;
    end else if (cfg_we_i && (cfg_idx_i <= REG_INTERCEPT)) begin
      // drop writes to indexes past the intercept
      coef_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  // The pipeline advances every cycle, so a transfer is never refused.
  assign busy_o = 1'b0;

  // ---------------------------------------------------------------------------
  // Front: SNR ratio division, ppm magnitude normalized to Q1.30
  // ---------------------------------------------------------------------------
  logic              accept;
  logic [15:0]       ppm_mag;
  logic [15:0]       ppm_v;
  logic [2:0]        ppm_int;
  front_side_t       fs_in;
  logic [1:0][47:0]  snr_num;
  logic [1:0][32:0]  snr_den;

  assign accept  = start_i && !busy_o;
  assign ppm_mag = mean_ppm_error_i[15] ? (~mean_ppm_error_i + 16'd1) : mean_ppm_error_i;
  assign ppm_v   = ppm_mag + 16'd256;

  // leading one of 256+|e| sits between bit 8 and bit 15
  always_comb begin
    ppm_int = '0;
    for (int b = 8; b < 16; b++) begin
      if (ppm_v[b]) ppm_int = 3'(b - 8);
    end
  end

  always_comb begin
    fs_in.empty   = group_empty_i;
    fs_in.cos_c   = charge_cosine_i;
    fs_in.cos_i   = isotope_cosine_i;
    fs_in.score   = charge_fit_score_i;
    fs_in.ppm_y   = q230_t'(ppm_v) << (5'd22 - {2'b0, ppm_int});
    fs_in.ppm_int = ppm_int;
  end

  // r = floor(s * 2^16 / (s + 2^16)) in Q0.16 for both SNR fields
  assign snr_num[0] = {charge_snr_i, 16'b0};
  assign snr_num[1] = {overall_snr_i, 16'b0};
  assign snr_den[0] = {1'b0, charge_snr_i} + 33'd65536;
  assign snr_den[1] = {1'b0, overall_snr_i} + 33'd65536;

  logic             dv1;
  front_side_t      fs_out;
  logic [1:0][15:0] snr_ratio;

  lqs_div_pipe #(
    .LANES  (2),
    .NW     (48),
    .DW     (33),
    .QW     (16),
    .SIDE_W ($bits(front_side_t))
  ) u_snr_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .side_i  (fs_in),
    .num_i   (snr_num),
    .den_i   (snr_den),
    .valid_o (dv1),
    .side_o  (fs_out),
    .quot_o  (snr_ratio)
  );

  // ---------------------------------------------------------------------------
  // log2 of all six features, fraction bits by repeated squaring
  // ---------------------------------------------------------------------------
  logic [5:0][30:0]        log_y;
  log_side_t               ls_in;
  log_side_t               ls_out;
  logic                    lv;
  logic [5:0][FRAC_W-1:0]  log_frac;

  assign log_y[0] = {1'b1, fs_out.cos_c, 14'b0};
  assign log_y[1] = {1'b1, snr_ratio[0], 14'b0};
  assign log_y[2] = {1'b1, fs_out.cos_i, 14'b0};
  assign log_y[3] = {1'b1, snr_ratio[1], 14'b0};
  assign log_y[4] = {1'b1, fs_out.score, 14'b0};
  assign log_y[5] = fs_out.ppm_y;

  assign ls_in.empty   = fs_out.empty;
  assign ls_in.ppm_int = fs_out.ppm_int;

  lqs_log2_pipe #(
    .LANES  (6),
    .SIDE_W ($bits(log_side_t))
  ) u_log2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dv1),
    .side_i  (ls_in),
    .y_i     (log_y),
    .valid_o (lv),
    .side_o  (ls_out),
    .frac_o  (log_frac)
  );

  // ---------------------------------------------------------------------------
  // Weighted sum: products, pair sums, then intercept and floor to Q.16
  // ---------------------------------------------------------------------------
  logic [5:0][18:0]   feat;
  logic signed [43:0] prod_q [6];
  logic               mul_v_q;
  logic               mul_empty_q;
  logic signed [44:0] pair_q [3];
  logic               pair_v_q;
  logic               pair_empty_q;
  logic signed [47:0] sum;
  logic signed [31:0] z_q;
  logic               z_v_q;
  logic               z_empty_q;
  logic signed [49:0] m_q;
  logic               m_v_q;
  logic               m_empty_q;

  always_comb begin
    for (int i = 0; i < 5; i++) feat[i] = {3'b0, log_frac[i]};
    feat[5] = {ls_out.ppm_int, log_frac[5]};
  end

  assign sum = (48'(coef_q[REG_INTERCEPT]) <<< 16)
             + 48'(pair_q[0]) + 48'(pair_q[1]) + 48'(pair_q[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_v_q  <= 1'b0;
      pair_v_q <= 1'b0;
      z_v_q    <= 1'b0;
      m_v_q    <= 1'b0;
    end else begin
      mul_v_q  <= lv;
      pair_v_q <= mul_v_q;
      z_v_q    <= pair_v_q;
      m_v_q    <= z_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 6; i++) begin
      prod_q[i] <= $signed({1'b0, feat[i]}) * coef_q[i];
    end
    mul_empty_q <= ls_out.empty;
    for (int j = 0; j < 3; j++) begin
      pair_q[j] <= 45'(prod_q[2*j]) + 45'(prod_q[2*j+1]);
    end
    pair_empty_q <= mul_empty_q;
    z_q          <= sum[47:16];
    z_empty_q    <= pair_empty_q;
    // t = floor(z * log2(e)) in Q.16 sits in bits [49:16]
    m_q          <= z_q * LOG2E_Q16;
    m_empty_q    <= z_empty_q;
  end

  // ---------------------------------------------------------------------------
  // 2^t: integer part n, fraction f; clamp far tails
  // ---------------------------------------------------------------------------
  logic signed [17:0] n_full;
  exp_side_t          es_in;
  exp_side_t          es_out;
  logic               ev;
  q230_t              pow;

  assign n_full       = $signed(m_q[49:32]);
  assign es_in.empty  = m_empty_q;
  assign es_in.sat_lo = n_full > 18'sd15;
  assign es_in.sat_hi = n_full < -18'sd30;
  assign es_in.n      = n_full[5:0];

  lqs_exp2_pipe #(
    .SIDE_W ($bits(exp_side_t))
  ) u_exp2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (m_v_q),
    .side_i  (es_in),
    .frac_i  (m_q[31:16]),
    .valid_o (ev),
    .side_o  (es_out),
    .pow_o   (pow)
  );

  // D = 1.0 + 2^f * 2^n in Q.30
  logic [46:0] term;
  logic [5:0]  n_neg;
  logic [46:0] den_q;
  logic        den_v_q;
  div_side_t   den_side_q;

  assign n_neg = 6'(-es_out.n);
  assign term  = es_out.n[5] ? (47'(pow) >> n_neg[4:0]) : (47'(pow) << es_out.n[4:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      den_v_q <= 1'b0;
    end else begin
      den_v_q <= ev;
    end
  end

  // drop the term in the clamped tails, where n is cut short, so D stays in range
  always_ff @(posedge clk_i) begin
    den_q             <= (47'd1 << 30) + ((es_out.sat_lo || es_out.sat_hi) ? 47'd0 : term);
    den_side_q.empty  <= es_out.empty;
    den_side_q.sat_lo <= es_out.sat_lo;
    den_side_q.sat_hi <= es_out.sat_hi;
  end

  // ---------------------------------------------------------------------------
  // q = floor(2^46 / D), 17 quotient bits, then saturate and register
  // ---------------------------------------------------------------------------
  logic [0:0][46:0] q_num;
  logic [0:0][46:0] q_den;
  logic             dv2;
  div_side_t        ds2;
  logic [0:0][16:0] q_raw;
  logic [15:0]      quality_d;
  logic             done_q;
  logic [15:0]      quality_q;

  assign q_num[0] = 47'd1 << 46;
  assign q_den[0] = den_q;

  lqs_div_pipe #(
    .LANES  (1),
    .NW     (47),
    .DW     (47),
    .QW     (17),
    .SIDE_W ($bits(div_side_t))
  ) u_recip_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (den_v_q),
    .side_i  (den_side_q),
    .num_i   (q_num),
    .den_i   (q_den),
    .valid_o (dv2),
    .side_o  (ds2),
    .quot_o  (q_raw)
  );

  always_comb begin
    priority if (ds2.empty || ds2.sat_lo) begin
      quality_d = '0;
    end else if (ds2.sat_hi || q_raw[0][16]) begin
      quality_d = 16'hFFFF;
    end else begin
      quality_d = q_raw[0][15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dv2;
    end
  end

  always_ff @(posedge clk_i) begin
    quality_q <= quality_d;
  end

  assign done_o    = done_q;
  assign quality_o = quality_q;

  `LQS_ASSERT(a_fixed_latency, done_o |-> $past(start_i && !busy_o, LATENCY))
  `LQS_ASSERT_NEXT(a_empty_gives_zero, dv2 && ds2.empty, done_o && (quality_o == 16'd0))

endmodule

`default_nettype wire

FILE: hw/rtl/lqs_div_pipe.sv
`default_nettype none
`include "logistic_quality_score_unit_assert.svh"

module lqs_div_pipe #(
  parameter int LANES  = 1,
  parameter int NW     = 48,
  parameter int DW     = 33,
  parameter int QW     = 16,
  parameter int SIDE_W = 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic [SIDE_W-1:0]             side_i,
  input  logic [LANES-1:0][NW-1:0]      num_i,
  input  logic [LANES-1:0][DW-1:0]      den_i,
  output logic                          valid_o,
  output logic [SIDE_W-1:0]             side_o,
  output logic [LANES-1:0][QW-1:0]      quot_o
);

  localparam int W = (NW > DW + QW) ? NW : DW + QW;

  logic                     valid_q [QW];
  logic [SIDE_W-1:0]        side_q  [QW];
  logic [LANES-1:0][W-1:0]  rem_q   [QW];
  logic [LANES-1:0][DW-1:0] den_q   [QW];
  logic [LANES-1:0][QW-1:0] quot_q  [QW];

  // one quotient bit per stage, most significant first
  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int J = QW - 1 - k;
    logic                     vld;
    logic [SIDE_W-1:0]        sd;
    logic [LANES-1:0][W-1:0]  rem;
    logic [LANES-1:0][DW-1:0] den;
    logic [LANES-1:0][QW-1:0] quot;
    logic [LANES-1:0][W-1:0]  rem_d;
    logic [LANES-1:0][QW-1:0] quot_d;

    if (k == 0) begin : g_head
      always_comb begin
        vld  = valid_i;
        sd   = side_i;
        den  = den_i;
        quot = '0;
        for (int l = 0; l < LANES; l++) rem[l] = W'(num_i[l]);
      end
    end else begin : g_body
      assign vld  = valid_q[k-1];
      assign sd   = side_q[k-1];
      assign rem  = rem_q[k-1];
      assign den  = den_q[k-1];
      assign quot = quot_q[k-1];
    end

    always_comb begin
      logic [W-1:0] trial;
      for (int l = 0; l < LANES; l++) begin
        trial     = W'(den[l]) << J;
        rem_d[l]  = rem[l];
        quot_d[l] = quot[l];
        if (rem[l] >= trial) begin
          rem_d[l]     = rem[l] - trial;
          quot_d[l][J] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else begin
        valid_q[k] <= vld;
      end
    end

    always_ff @(posedge clk_i) begin
      side_q[k] <= sd;
      rem_q[k]  <= rem_d;
      den_q[k]  <= den;
      quot_q[k] <= quot_d;
    end
  end

  assign valid_o = valid_q[QW-1];
  assign side_o  = side_q[QW-1];
  assign quot_o  = quot_q[QW-1];

  for (genvar l = 0; l < LANES; l++) begin : g_chk
    `LQS_ASSERT(a_rem_below_den, valid_q[QW-1] |-> (rem_q[QW-1][l] < W'(den_q[QW-1][l])))
  end

endmodule

`default_nettype wire

FILE: hw/rtl/lqs_log2_pipe.sv
`default_nettype none
`include "logistic_quality_score_unit_assert.svh"

module lqs_log2_pipe #(
  parameter int LANES  = 6,
  parameter int SIDE_W = 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic [SIDE_W-1:0]             side_i,
  input  logic [LANES-1:0][30:0]        y_i,
  output logic                          valid_o,
  output logic [SIDE_W-1:0]             side_o,
  output logic [LANES-1:0][lqs_pkg::FRAC_W-1:0] frac_o
);

  import lqs_pkg::*;

  logic                         valid_q [FRAC_W];
  logic [SIDE_W-1:0]            side_q  [FRAC_W];
  logic [LANES-1:0][30:0]       y_q     [FRAC_W];
  logic [LANES-1:0][FRAC_W-1:0] frac_q  [FRAC_W];

  // square, and take one fraction bit when the square reaches 2.0
  for (genvar k = 0; k < FRAC_W; k++) begin : g_stage
    logic                         vld;
    logic [SIDE_W-1:0]            sd;
    logic [LANES-1:0][30:0]       y;
    logic [LANES-1:0][FRAC_W-1:0] fr;
    logic [LANES-1:0][30:0]       y_d;
    logic [LANES-1:0][FRAC_W-1:0] fr_d;

    if (k == 0) begin : g_head
      assign vld = valid_i;
      assign sd  = side_i;
      assign y   = y_i;
      assign fr  = '0;
    end else begin : g_body
      assign vld = valid_q[k-1];
      assign sd  = side_q[k-1];
      assign y   = y_q[k-1];
      assign fr  = frac_q[k-1];
    end

    always_comb begin
      logic [61:0] sq;
      for (int l = 0; l < LANES; l++) begin
        sq = 62'(y[l]) * 62'(y[l]);
        if (sq[61]) begin
          y_d[l]  = sq[61:31];
          fr_d[l] = {fr[l][FRAC_W-2:0], 1'b1};
        end else begin
          y_d[l]  = sq[60:30];
          fr_d[l] = {fr[l][FRAC_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else begin
        valid_q[k] <= vld;
      end
    end

    always_ff @(posedge clk_i) begin
      side_q[k] <= sd;
      y_q[k]    <= y_d;
      frac_q[k] <= fr_d;
    end
  end

  assign valid_o = valid_q[FRAC_W-1];
  assign side_o  = side_q[FRAC_W-1];
  assign frac_o  = frac_q[FRAC_W-1];

  for (genvar l = 0; l < LANES; l++) begin : g_chk
    `LQS_ASSERT(a_y_normalized, valid_q[FRAC_W-1] |-> y_q[FRAC_W-1][l][30])
  end

endmodule

`default_nettype wire

FILE: hw/rtl/lqs_exp2_pipe.sv
`default_nettype none
`include "logistic_quality_score_unit_assert.svh"

module lqs_exp2_pipe #(
  parameter int SIDE_W = 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic [SIDE_W-1:0]          side_i,
  input  logic [lqs_pkg::FRAC_W-1:0] frac_i,
  output logic                       valid_o,
  output logic [SIDE_W-1:0]          side_o,
  output lqs_pkg::q230_t             pow_o
);

  import lqs_pkg::*;

  logic              valid_q [FRAC_W];
  logic [SIDE_W-1:0] side_q  [FRAC_W];
  logic [FRAC_W-1:0] frac_q  [FRAC_W];
  q230_t             pow_q   [FRAC_W];

  // multiply in 2^(2^-i) for each set fraction bit, most significant first
  for (genvar k = 0; k < FRAC_W; k++) begin : g_stage
    localparam int    J    = FRAC_W - 1 - k;
    localparam q230_t COEF = exp2_coef(k + 1);
    logic              vld;
    logic [SIDE_W-1:0] sd;
    logic [FRAC_W-1:0] fr;
    q230_t             p;
    logic [61:0]       prod;
    q230_t             p_d;

    if (k == 0) begin : g_head
      assign vld = valid_i;
      assign sd  = side_i;
      assign fr  = frac_i;
      assign p   = q230_t'(1) << 30;
    end else begin : g_body
      assign vld = valid_q[k-1];
      assign sd  = side_q[k-1];
      assign fr  = frac_q[k-1];
      assign p   = pow_q[k-1];
    end

    assign prod = 62'(p) * 62'(COEF);
    assign p_d  = fr[J] ? prod[60:30] : p;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else begin
        valid_q[k] <= vld;
      end
    end

    always_ff @(posedge clk_i) begin
      side_q[k] <= sd;
      frac_q[k] <= fr;
      pow_q[k]  <= p_d;
    end
  end

  assign valid_o = valid_q[FRAC_W-1];
  assign side_o  = side_q[FRAC_W-1];
  assign pow_o   = pow_q[FRAC_W-1];

  `LQS_ASSERT(a_pow_at_least_one, valid_q[FRAC_W-1] |-> pow_q[FRAC_W-1][30])

endmodule

`default_nettype wire
